### rtl/core/tle_pkg.sv
// Shared constants and types of the terminal line editor.
package tle_pkg;

	// Size of the line store as seen by the editing logic
	localparam int STORE_SIZE = 32;
	localparam int LIMIT_W    = 6;
	localparam int FILL_W     = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

	// Character codes
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	// Result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT,
		S_LINE,
		S_DONE
	} state_t;

	// Echo sequences
	typedef enum logic [1:0] {
		SEQ_NL,
		SEQ_RUB,
		SEQ_ONE
	} seq_t;

endpackage

### rtl/core/tle_if.sv
// Handshake channels for raw bytes and editor results.
interface tle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;

	modport source (output valid, output raw_byte, input ready);
	modport sink (input valid, input raw_byte, output ready);
endinterface

interface tle_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [4:0] line_length;
	logic       last;

	modport source (output valid, output out_byte, output kind, output line_length,
		output last, input ready);
	modport sink (input valid, input out_byte, input kind, input line_length,
		input last, output ready);
endinterface

### rtl/core/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; hold data while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/tle_seq.sv
// Line-editing sequencer: decode, shared step counter, line store and result register.
module tle_seq import tle_pkg::*; #(
	parameter int LINE_DEPTH = STORE_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] eff_limit,
	tle_rx_if.sink             rx,
	tle_tx_if.source           tx
);

	localparam int STORE_DEPTH = (LINE_DEPTH < STORE_SIZE) ? LINE_DEPTH : STORE_SIZE;
	localparam int AW          = $clog2(STORE_DEPTH);

	state_t state_q, state_d;
	seq_t   seq_q;

	logic [7:0]        byte_q;
	logic [FILL_W-1:0] idx_q;
	logic [FILL_W-1:0] cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic              cr_q;

	logic              tx_valid_q;
	logic [7:0]        tx_byte_q;
	logic [1:0]        tx_kind_q;
	logic [FILL_W-1:0] tx_len_q;
	logic              tx_last_q;

	logic              acc, is_cr, is_lf, is_rub, newline, drop, room, store;
	logic              emit_ok, emit, step_end;
	logic [FILL_W-1:0] bound, idx_inc;
	logic [7:0]        e_byte;
	logic [1:0]        e_kind;
	logic [FILL_W-1:0] e_len;
	logic              e_last;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [7:0]        ram_rdata;

	// Decode the incoming byte
	assign acc     = rx.valid && rx.ready;
	assign is_cr   = (rx.raw_byte == CH_CR);
	assign is_lf   = (rx.raw_byte == CH_LF);
	assign is_rub  = (rx.raw_byte == CH_BS) || (rx.raw_byte == CH_DEL);
	assign newline = is_cr || (is_lf && !cr_q);
	assign drop    = (is_lf && cr_q) || (!is_cr && !is_lf && rx.raw_byte == CH_ESC);
	assign room    = ({1'b0, fill_q} + 6'd1) < eff_limit;
	assign store   = !newline && !drop && !is_rub;

	assign rx.ready = (state_q == S_IDLE);

	// Shared step counter: one increment and one compare against the current bound
	always_comb begin
		bound = cnt_q;
		if (state_q == S_EMIT) begin
			case (seq_q)
				SEQ_NL:  bound = 5'd2;
				SEQ_RUB: bound = 5'd3;
				default: bound = 5'd1;
			endcase
		end
	end

	assign idx_inc  = idx_q + 5'd1;
	assign step_end = (idx_inc == bound);
	assign emit_ok  = !tx_valid_q || tx.ready;
	assign emit     = (state_q != S_IDLE) && emit_ok;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && !drop) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_ok && step_end) begin
					if (seq_q == SEQ_NL) begin
						state_d = (cnt_q != '0) ? S_LINE : S_DONE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_LINE: begin
				if (emit_ok && step_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (emit_ok) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Result selection
	always_comb begin
		e_byte = CH_NUL;
		e_kind = KIND_ECHO;
		e_len  = '0;
		e_last = 1'b0;
		unique case (state_q)
			S_EMIT: begin
				case (seq_q)
					SEQ_NL:  e_byte = (idx_q == '0) ? CH_CR : CH_LF;
					SEQ_RUB: e_byte = (idx_q == 5'd1) ? CH_SP : CH_BS;
					default: e_byte = byte_q;
				endcase
				e_last = step_end && (seq_q != SEQ_NL);
			end
			S_LINE: begin
				e_byte = ram_rdata;
				e_kind = KIND_CHAR;
			end
			S_DONE: begin
				e_kind = KIND_DONE;
				e_len  = cnt_q;
				e_last = 1'b1;
			end
			default: e_byte = CH_NUL;
		endcase
	end

	// Line store access: write on a stored character, prefetch during line output
	assign ram_we    = acc && store && room;
	assign ram_waddr = fill_q[AW-1:0];
	assign ram_re    = emit && ((state_q == S_EMIT && seq_q == SEQ_NL && step_end)
		|| state_q == S_LINE);
	assign ram_raddr = (state_q == S_LINE) ? idx_inc[AW-1:0] : '0;

	tle_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx.raw_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			fill_q  <= '0;
			cr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				idx_q <= '0;
				cr_q  <= is_cr;
				if (newline) begin
					fill_q <= '0;
				end else if (is_rub && !drop && fill_q != '0) begin
					fill_q <= fill_q - 5'd1;
				end else if (store && room) begin
					fill_q <= fill_q + 5'd1;
				end
			end else if (emit) begin
				idx_q <= step_end ? '0 : idx_inc;
			end
		end
	end

	// Latch the sequence chosen for the accepted item
	always_ff @(posedge clk) begin
		if (acc) begin
			if (newline) begin
				seq_q <= SEQ_NL;
				cnt_q <= fill_q;
			end else if (is_rub && fill_q != '0) begin
				seq_q <= SEQ_RUB;
			end else begin
				seq_q <= SEQ_ONE;
			end
			byte_q <= (store && room) ? rx.raw_byte : CH_BEL;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (emit) begin
			tx_valid_q <= 1'b1;
		end else if (tx.ready) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_byte_q <= e_byte;
			tx_kind_q <= e_kind;
			tx_len_q  <= e_len;
			tx_last_q <= e_last;
		end
	end

	assign tx.valid       = tx_valid_q;
	assign tx.out_byte    = tx_byte_q;
	assign tx.kind        = tx_kind_q;
	assign tx.line_length = tx_len_q;
	assign tx.last        = tx_last_q;

`ifndef SYNTH
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid_q && tx_kind_q == KIND_DONE) |-> tx_last_q)
		else $error("line complete result not marked last");

	a_char_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid_q && tx_kind_q == KIND_CHAR) |-> !tx_last_q)
		else $error("line character marked last");

	a_line_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINE) |-> (cnt_q != '0))
		else $error("line output entered with empty line");

	a_fill_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, fill_q} < 6'(STORE_DEPTH)))
		else $error("line store write beyond depth");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !rx.ready)
		else $error("item accepted while sequencer busy");
`endif

endmodule

### rtl/core/terminal_line_editor.sv
// Terminal line editor top level: limit register and line-editing sequencer.
// Throughput: one result per cycle from the sequencer's step counter while results are
// taken. A plain byte echoes once (BEL when not stored); backspace on a non-empty line
// gives BS, space, BS; newline gives CR, LF, the stored characters and a done result.
// The next item is accepted once the final result of the previous one is registered.
// Reset (arst_n, asynchronous, active low): empty line, no pending CR, limit 32.
module terminal_line_editor import tle_pkg::*; #(
	parameter int LINE_DEPTH = STORE_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	tle_rx_if.sink             rx,
	tle_tx_if.source           tx
);

	localparam int STORE_DEPTH = (LINE_DEPTH < STORE_SIZE) ? LINE_DEPTH : STORE_SIZE;

	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] eff_limit;

	// Line limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Clamp the limit to the store depth
	assign eff_limit = (limit_q > LIMIT_W'(STORE_DEPTH)) ? LIMIT_W'(STORE_DEPTH) : limit_q;

	tle_seq #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_limit (eff_limit),
		.rx        (rx),
		.tx        (tx)
	);

endmodule
